// ----- rtl/core/lcnc_pkg.sv -----
// Shared types, codes and constants of the Luhn card number classifier.
package lcnc_pkg;

    localparam int CARD_BITS = 54;
    localparam int CNT_W     = 6;
    localparam int DCNT_W    = 5;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_VISA    = 2'd1,
        KIND_AMEX    = 2'd2,
        KIND_MASTER  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CONVERT,
        ST_SCAN,
        ST_FINISH
    } t_state;

    localparam logic [DCNT_W-1:0] LEN_VISA_SHORT = 5'd13;
    localparam logic [DCNT_W-1:0] LEN_AMEX       = 5'd15;
    localparam logic [DCNT_W-1:0] LEN_LONG       = 5'd16;
    localparam logic [3:0]        LEAD_VISA      = 4'd4;
    localparam logic [6:0]        LEAD_AMEX_LO   = 7'd34;
    localparam logic [6:0]        LEAD_AMEX_HI   = 7'd37;
    localparam logic [6:0]        LEAD_MC_LO     = 7'd51;
    localparam logic [6:0]        LEAD_MC_HI     = 7'd55;
    localparam logic [3:0]        DEC_BASE       = 4'd10;

    typedef struct packed {
        logic              load;
        logic              shift;
        logic              scan;
        logic              odd;
        logic [DCNT_W-1:0] dnum;
        logic              capture;
    } t_cmd;

    typedef struct packed {
        logic ovf;
    } t_status;

    // Ten to the power n, worked out at elaboration.
    function automatic logic [64:0] pow10(input int n);
        logic [64:0] p;
        p = 65'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 65'd10;
        end
        return p;
    endfunction

endpackage

// ----- rtl/core/lcnc_dpath.sv -----
// Datapath: binary to BCD conversion, digit scan with Luhn sum, classification.
module lcnc_dpath #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                                i_clk,
    input  logic [lcnc_pkg::CARD_BITS-1:0]      i_card_number,
    input  lcnc_pkg::t_cmd                      i_cmd,
    output lcnc_pkg::t_status                   o_status,
    output logic [1:0]                          o_card_kind,
    output logic                                o_checksum_ok,
    output logic [lcnc_pkg::DCNT_W-1:0]         o_num_digits
);

    localparam int          BCD_W = 4 * MAX_DIGITS;
    localparam logic [64:0] LIMIT = lcnc_pkg::pow10(MAX_DIGITS);

    logic [lcnc_pkg::CARD_BITS-1:0] r_bin;
    logic [BCD_W-1:0]               r_bcd;
    logic [3:0]                     r_sum;
    logic [lcnc_pkg::DCNT_W-1:0]    r_cnt;
    logic [3:0]                     r_lead1;
    logic [6:0]                     r_lead2;
    logic [3:0]                     r_prev;
    logic                           r_ovf;
    lcnc_pkg::t_kind                r_kind;
    logic                           r_ok;
    logic [lcnc_pkg::DCNT_W-1:0]    r_count;

    logic             ovf_in;
    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       dig;
    logic [4:0]       dig2;
    logic [4:0]       dval;
    logic [4:0]       sum_raw;
    logic [3:0]       sum_next;
    logic [6:0]       dig_x10;
    logic             ok;
    lcnc_pkg::t_kind  kind;

    assign ovf_in = {11'd0, i_card_number} >= LIMIT;

    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                bcd_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                bcd_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    // Even places are doubled; a two-digit double adds its digits, i.e. minus nine.
    always_comb begin
        dig  = r_bcd[3:0];
        dig2 = {dig, 1'b0};
        if (!i_cmd.odd) begin
            dval = {1'b0, dig};
        end else if (dig2 >= 5'd10) begin
            dval = dig2 - 5'd9;
        end else begin
            dval = dig2;
        end
        sum_raw = {1'b0, r_sum} + dval;
        if (sum_raw >= {1'b0, lcnc_pkg::DEC_BASE}) begin
            sum_next = 4'(sum_raw - {1'b0, lcnc_pkg::DEC_BASE});
        end else begin
            sum_next = sum_raw[3:0];
        end
        dig_x10 = {dig, 3'b000} + {2'b00, dig, 1'b0};
    end

    always_comb begin
        ok = (r_sum == 4'd0);
        if (!ok) begin
            kind = lcnc_pkg::KIND_INVALID;
        end else if (r_cnt == lcnc_pkg::LEN_VISA_SHORT && r_lead1 == lcnc_pkg::LEAD_VISA) begin
            kind = lcnc_pkg::KIND_VISA;
        end else if (r_cnt == lcnc_pkg::LEN_AMEX &&
                     (r_lead2 == lcnc_pkg::LEAD_AMEX_LO || r_lead2 == lcnc_pkg::LEAD_AMEX_HI)) begin
            kind = lcnc_pkg::KIND_AMEX;
        end else if (r_cnt == lcnc_pkg::LEN_LONG &&
                     r_lead2 >= lcnc_pkg::LEAD_MC_LO && r_lead2 <= lcnc_pkg::LEAD_MC_HI) begin
            kind = lcnc_pkg::KIND_MASTER;
        end else if (r_cnt == lcnc_pkg::LEN_LONG && r_lead1 == lcnc_pkg::LEAD_VISA) begin
            kind = lcnc_pkg::KIND_VISA;
        end else begin
            kind = lcnc_pkg::KIND_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin   <= i_card_number;
            r_bcd   <= '0;
            r_sum   <= 4'd0;
            r_cnt   <= 5'd1;
            r_lead1 <= 4'd0;
            r_lead2 <= 7'd0;
            r_prev  <= 4'd0;
            r_ovf   <= ovf_in;
        end
        if (i_cmd.shift) begin
            r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[lcnc_pkg::CARD_BITS-1]};
            r_bin <= {r_bin[lcnc_pkg::CARD_BITS-2:0], 1'b0};
        end
        if (i_cmd.scan) begin
            r_sum  <= sum_next;
            r_prev <= dig;
            r_bcd  <= {4'd0, r_bcd[BCD_W-1:4]};
            if (dig != 4'd0) begin
                r_cnt   <= i_cmd.dnum;
                r_lead1 <= dig;
                if (i_cmd.dnum == 5'd1) begin
                    r_lead2 <= {3'd0, dig};
                end else begin
                    r_lead2 <= dig_x10 + {3'd0, r_prev};
                end
            end
        end
        if (i_cmd.capture) begin
            if (r_ovf) begin
                r_kind  <= lcnc_pkg::KIND_INVALID;
                r_ok    <= 1'b0;
                r_count <= '0;
            end else begin
                r_kind  <= kind;
                r_ok    <= ok;
                r_count <= r_cnt;
            end
        end
    end

    assign o_status.ovf  = r_ovf;
    assign o_card_kind   = r_kind;
    assign o_checksum_ok = r_ok;
    assign o_num_digits  = r_count;

endmodule

// ----- rtl/core/lcnc_ctrl.sv -----
// Controller: sequences range check, conversion, digit scan and result handoff.
module lcnc_ctrl #(
    parameter int MAX_DIGITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  lcnc_pkg::t_status i_status,
    output lcnc_pkg::t_cmd    o_cmd
);

    localparam logic [lcnc_pkg::CNT_W-1:0] LAST_BIT   = 6'(lcnc_pkg::CARD_BITS - 1);
    localparam logic [lcnc_pkg::CNT_W-1:0] LAST_DIGIT = 6'(MAX_DIGITS - 1);

    lcnc_pkg::t_state              r_state, n_state;
    logic [lcnc_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcnc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid && i_out_stall;
        o_in_stall    = 1'b1;
        o_cmd         = '0;
        o_cmd.odd     = r_cnt[0];
        o_cmd.dnum    = r_cnt[lcnc_pkg::DCNT_W-1:0] + 5'd1;
        unique case (r_state)
            lcnc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lcnc_pkg::ST_CHECK;
                end
            end
            lcnc_pkg::ST_CHECK: begin
                n_cnt = '0;
                if (i_status.ovf) begin
                    n_state = lcnc_pkg::ST_FINISH;
                end else begin
                    n_state = lcnc_pkg::ST_CONVERT;
                end
            end
            lcnc_pkg::ST_CONVERT: begin
                o_cmd.shift = 1'b1;
                if (r_cnt == LAST_BIT) begin
                    n_cnt   = '0;
                    n_state = lcnc_pkg::ST_SCAN;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            lcnc_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_cnt == LAST_DIGIT) begin
                    n_cnt   = '0;
                    n_state = lcnc_pkg::ST_FINISH;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            lcnc_pkg::ST_FINISH: begin
                // The output register is free when empty or taken in this cycle.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = lcnc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lcnc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == lcnc_pkg::ST_CHECK))
        else $error("accepted item did not start the range check");

    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_out_valid)
        else $error("captured result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (!r_out_valid || !i_out_stall))
        else $error("result captured over a pending result");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcnc_pkg::ST_SCAN) |-> (r_cnt <= LAST_DIGIT))
        else $error("digit index out of range");

    a_convert_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcnc_pkg::ST_CONVERT && r_cnt == LAST_BIT) |=>
        (r_state == lcnc_pkg::ST_SCAN))
        else $error("conversion did not hand over to the digit scan");

endmodule

// ----- rtl/core/luhn_card_number_classifier_core.sv -----
// Top level of the Luhn card number classifier: controller plus datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_card_number
//  out     | output    | o_out_valid / i_out_stall | o_card_kind, o_checksum_ok, o_num_digits
//
// An accepted item passes from a range check through the shift-add-3 converter, one input
// bit at a time, and the Luhn scan, one decimal digit at a time, to the capture into the
// result register; an out-of-range number goes from the range check straight to the capture.
// A new item is taken only in the idle state, which follows the capture.
// Reset is synchronous and active low; it clears the controller and the output valid.
// A stalled result holds; the next item is still taken and then waits in the capture state.
module luhn_card_number_classifier_core #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lcnc_pkg::CARD_BITS-1:0]   i_card_number,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_card_kind,
    output logic                             o_checksum_ok,
    output logic [lcnc_pkg::DCNT_W-1:0]      o_num_digits
);

    lcnc_pkg::t_cmd    cmd;
    lcnc_pkg::t_status status;

    lcnc_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lcnc_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_card_number (i_card_number),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_card_kind   (o_card_kind),
        .o_checksum_ok (o_checksum_ok),
        .o_num_digits  (o_num_digits)
    );

endmodule

// ----- bench/luhn_checker.sv -----
// Checker for the Luhn card number classifier: predicts and compares every result item.
module luhn_checker #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [lcnc_pkg::CARD_BITS-1:0] i_card_number,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [1:0]                     i_card_kind,
    input  logic                           i_checksum_ok,
    input  logic [lcnc_pkg::DCNT_W-1:0]    i_num_digits,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_idle_cycles
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [lcnc_pkg::CARD_BITS-1:0] number;
        lcnc_pkg::t_kind                kind;
        logic                           ok;
        logic [lcnc_pkg::DCNT_W-1:0]    count;
    } t_card_verdict;

    t_card_verdict verdict_q[$];
    int            fail_total;
    int            idle_run;
    int            verdicts_checked;
    int            kind_seen[4];
    int            bad_sum_seen;
    int            too_long_seen;

    assign o_fail_count  = fail_total;
    assign o_pending     = verdict_q.size();
    assign o_idle_cycles = idle_run;

    function automatic t_card_verdict classify_card(
        input logic [lcnc_pkg::CARD_BITS-1:0] number);
        longint unsigned rest;
        longint unsigned span;
        int unsigned     digit[MAX_DIGITS];
        int unsigned     sum;
        int unsigned     count;
        int unsigned     lead1;
        int unsigned     lead2;
        int unsigned     d;
        t_card_verdict   v;
        v.number = number;
        rest     = number;
        span     = 1;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            span = span * 10;
        end
        if (rest >= span) begin
            v.kind  = lcnc_pkg::KIND_INVALID;
            v.ok    = 1'b0;
            v.count = '0;
            return v;
        end
        count = 1;
        sum   = 0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            digit[i] = int'(rest % 10);
            rest     = rest / 10;
            if (digit[i] != 0) begin
                count = i + 1;
            end
        end
        // Every second digit from the right is doubled and its two digits are added.
        for (int i = 0; i < MAX_DIGITS; i++) begin
            d = digit[i];
            if (i % 2 == 1) begin
                d = 2 * d;
                if (d >= 10) begin
                    d = d - 9;
                end
            end
            sum = sum + d;
        end
        v.ok  = (sum % 10 == 0);
        lead1 = digit[count-1];
        lead2 = (count >= 2) ? lead1 * 10 + digit[count-2] : lead1;
        if (!v.ok) begin
            v.kind = lcnc_pkg::KIND_INVALID;
        end else if (count == lcnc_pkg::LEN_VISA_SHORT && lead1 == lcnc_pkg::LEAD_VISA) begin
            v.kind = lcnc_pkg::KIND_VISA;
        end else if (count == lcnc_pkg::LEN_AMEX &&
                     (lead2 == lcnc_pkg::LEAD_AMEX_LO || lead2 == lcnc_pkg::LEAD_AMEX_HI)) begin
            v.kind = lcnc_pkg::KIND_AMEX;
        end else if (count == lcnc_pkg::LEN_LONG &&
                     lead2 >= lcnc_pkg::LEAD_MC_LO && lead2 <= lcnc_pkg::LEAD_MC_HI) begin
            v.kind = lcnc_pkg::KIND_MASTER;
        end else if (count == lcnc_pkg::LEN_LONG && lead1 == lcnc_pkg::LEAD_VISA) begin
            v.kind = lcnc_pkg::KIND_VISA;
        end else begin
            v.kind = lcnc_pkg::KIND_INVALID;
        end
        v.count = lcnc_pkg::DCNT_W'(count);
        return v;
    endfunction

    task automatic compare_field(input string field,
                                 input logic [lcnc_pkg::CARD_BITS-1:0] number,
                                 input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t ns: card %0d: %s expected %0d, got %0d",
                     $time, number, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_card_verdict want;
        if (!i_rst_n) begin
            idle_run <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                verdict_q.push_back(classify_card(i_card_number));
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    fail_total++;
                    $display({"%0t ns: result with no item outstanding: expected none, ",
                              "got kind %0d ok %0d digits %0d"},
                             $time, i_card_kind, i_checksum_ok, i_num_digits);
                end else begin
                    want = verdict_q.pop_front();
                    compare_field("card_kind", want.number, 8'(want.kind), 8'(i_card_kind));
                    compare_field("checksum_ok", want.number, 8'(want.ok), 8'(i_checksum_ok));
                    compare_field("num_digits", want.number, 8'(want.count), 8'(i_num_digits));
                    verdicts_checked++;
                    kind_seen[want.kind]++;
                    if (want.count == 0) begin
                        too_long_seen++;
                    end else if (!want.ok) begin
                        bad_sum_seen++;
                    end
                end
            end
            if ((i_in_valid && !i_in_stall) || (i_out_valid && !i_out_stall)) begin
                idle_run <= 0;
            end else begin
                idle_run <= idle_run + 1;
            end
        end
    end

    function void report_coverage();
        $display("Checked %0d results: %0d visa, %0d amex, %0d mastercard, %0d invalid.",
                 verdicts_checked, kind_seen[lcnc_pkg::KIND_VISA],
                 kind_seen[lcnc_pkg::KIND_AMEX], kind_seen[lcnc_pkg::KIND_MASTER],
                 kind_seen[lcnc_pkg::KIND_INVALID]);
        $display("Of the invalid ones %0d had a bad checksum and %0d had more than %0d digits.",
                 bad_sum_seen, too_long_seen, MAX_DIGITS);
    endfunction

endmodule

// ----- bench/tb.sv -----
// Testbench top of the Luhn card number classifier: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIGITS    = 16;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int WATCHDOG_IDLE = 4000;
    localparam int DRAIN_EVERY   = 500;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [lcnc_pkg::CARD_BITS-1:0] i_card_number;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [1:0]                     o_card_kind;
    logic                           o_checksum_ok;
    logic [lcnc_pkg::DCNT_W-1:0]    o_num_digits;
    int                             fail_count;
    int                             pending;
    int                             idle_cycles;

    luhn_card_number_classifier_core #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_card_number(i_card_number),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_card_kind  (o_card_kind),
        .o_checksum_ok(o_checksum_ok),
        .o_num_digits (o_num_digits)
    );

    luhn_checker #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_card_number(i_card_number),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_card_kind  (o_card_kind),
        .i_checksum_ok(o_checksum_ok),
        .i_num_digits (o_num_digits),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_idle_cycles(idle_cycles)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned decimal_span(input int digits);
        longint unsigned span;
        span = 1;
        for (int i = 0; i < digits; i++) begin
            span = span * 10;
        end
        return span;
    endfunction

    // Appends the one check digit that makes the whole number pass the Luhn test.
    function automatic longint unsigned append_check_digit(input longint unsigned body);
        longint unsigned rest;
        int unsigned     sum;
        int unsigned     d;
        int unsigned     pos;
        rest = body;
        sum  = 0;
        pos  = 0;
        while (rest != 0) begin
            d    = int'(rest % 10);
            rest = rest / 10;
            if (pos % 2 == 0) begin
                d = 2 * d;
                if (d >= 10) begin
                    d = d - 9;
                end
            end
            sum = sum + d;
            pos++;
        end
        return body * 10 + (10 - sum % 10) % 10;
    endfunction

    function automatic longint unsigned luhn_card(input int unsigned prefix, input int prefix_len,
                                                  input int len);
        longint unsigned body;
        body = prefix;
        for (int i = prefix_len; i < len - 1; i++) begin
            body = body * 10 + $urandom_range(9);
        end
        return append_check_digit(body);
    endfunction

    // Changes the last digit, which is never doubled, so the Luhn test must fail.
    function automatic longint unsigned spoil_check(input longint unsigned card);
        int unsigned d;
        d = int'(card % 10);
        return card - d + (d + $urandom_range(1, 9)) % 10;
    endfunction

    function automatic longint unsigned branded_card();
        case ($urandom_range(3))
            0: return luhn_card(4, 1, 13);
            1: return luhn_card($urandom_range(1) ? 34 : 37, 2, 15);
            2: return luhn_card($urandom_range(51, 55), 2, 16);
            default: return luhn_card(4, 1, 16);
        endcase
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 120);
    endfunction

    // Holds the item until it is taken; a gap of zero leaves valid high for the next one.
    task automatic send_item(input longint unsigned card, input int gap);
        i_in_valid    <= 1'b1;
        i_card_number <= card[lcnc_pkg::CARD_BITS-1:0];
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin
        int run;
        int free;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            run = idle_gap();
            if (run > 0) begin
                i_out_stall <= 1'b1;
                repeat (run) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            free = ($urandom_range(19) == 0) ? $urandom_range(150, 400) : $urandom_range(1, 8);
            repeat (free) @(negedge i_clk);
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_IDLE);
        $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_IDLE);
        $display("FAILURE");
        $finish;
    end

    initial begin
        longint unsigned cards[$];
        longint unsigned card;
        int              gap;
        int              r;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_card_number = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extremes, range limit, every brand, near misses of the brand rules.
        cards.push_back(0);
        cards.push_back(7);
        cards.push_back(decimal_span(MAX_DIGITS) - 1);
        cards.push_back(decimal_span(MAX_DIGITS));
        cards.push_back(64'h003F_FFFF_FFFF_FFFF);
        cards.push_back(decimal_span(MAX_DIGITS - 1));
        cards.push_back(luhn_card(4, 1, 13));
        cards.push_back(luhn_card(4, 1, 16));
        cards.push_back(luhn_card(34, 2, 15));
        cards.push_back(luhn_card(37, 2, 15));
        for (int p = 51; p <= 55; p++) begin
            cards.push_back(luhn_card(p, 2, 16));
        end
        cards.push_back(luhn_card(4, 1, 14));
        cards.push_back(luhn_card(4, 1, 15));
        cards.push_back(luhn_card(4, 1, 12));
        cards.push_back(luhn_card(34, 2, 16));
        cards.push_back(luhn_card(35, 2, 15));
        cards.push_back(luhn_card(50, 2, 16));
        cards.push_back(luhn_card(56, 2, 16));
        cards.push_back(spoil_check(luhn_card(4, 1, 13)));
        cards.push_back(spoil_check(luhn_card(53, 2, 16)));
        foreach (cards[k]) begin
            send_item(cards[k], (k == cards.size() - 1) ? 1 : idle_gap());
        end
        wait (pending == 0);
        @(negedge i_clk);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                card = branded_card();
            end else if (r < 60) begin
                card = spoil_check(branded_card());
            end else if (r < 72) begin
                gap  = $urandom_range(1, MAX_DIGITS);
                card = (gap == 1) ? 0 : luhn_card($urandom_range(1, 9), 1, gap);
            end else if (r < 80) begin
                card = luhn_card($urandom_range(10, 99), 2, $urandom_range(13, 16));
            end else if (r < 92) begin
                card = {$urandom, $urandom};
                card = card & 64'h003F_FFFF_FFFF_FFFF;
            end else begin
                card = {$urandom, $urandom};
                card = card % decimal_span($urandom_range(1, MAX_DIGITS));
            end
            // A burst without input gaps in the first quarter of every two hundred items.
            gap = (i % 200 < 50) ? 0 : idle_gap();
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1 || i == RANDOM_ITEMS - 1) begin
                gap = gap + 1;
            end
            send_item(card, gap);
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
                wait (pending == 0);
                @(negedge i_clk);
            end
        end

        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        u_chk.report_coverage();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
